// ===== rtl/hkrb_pkg.sv =====
package hkrb_pkg;

	localparam int unsigned KEY_W = 8;
	localparam int unsigned SHOWN_SLOTS = 6;

	// input kinds
	localparam logic [1:0] KIND_PRESS = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_RELEASE_ALL = 2'd2;
	localparam logic [1:0] KIND_TYPE = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// key code ranges
	localparam logic [7:0] CODE_MODIFIER_BASE = 8'd128;
	localparam logic [7:0] CODE_RAW_BASE = 8'd136;

	// table entry bits
	localparam logic [7:0] SHIFT_FLAG = 8'h80;
	localparam logic [7:0] USAGE_MASK = 8'h7f;
	localparam logic [7:0] LEFT_SHIFT_BIT = 8'h02;

	// ascii to usage, top bit asks for left shift, zero is unmapped
	localparam logic [7:0] CHAR_MAP [128] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
		8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
		8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
		8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
		8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
		8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
		8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
		8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
		8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
		8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
		8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
		8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
	};

	// outcome of resolving one key code
	typedef struct packed {
		logic       mapped;
		logic [7:0] usage;
		logic [7:0] modifier;
	} resolve_t;

endpackage

// ===== rtl/hkrb_event_if.sv =====
interface hkrb_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] key_code;

	modport source (output valid, output kind, output key_code, input ready);
	modport sink (input valid, input kind, input key_code, output ready);
endinterface

// ===== rtl/hkrb_report_if.sv =====
interface hkrb_report_if;
	logic       valid;
	logic       ready;
	logic       report_valid;
	logic [1:0] status;
	logic       last;
	logic [7:0] modifier_bits;
	logic [7:0] slot_zero;
	logic [7:0] slot_one;
	logic [7:0] slot_two;
	logic [7:0] slot_three;
	logic [7:0] slot_four;
	logic [7:0] slot_five;

	modport source (
		output valid, output report_valid, output status, output last,
		output modifier_bits, output slot_zero, output slot_one, output slot_two,
		output slot_three, output slot_four, output slot_five,
		input ready
	);
	modport sink (
		input valid, input report_valid, input status, input last,
		input modifier_bits, input slot_zero, input slot_one, input slot_two,
		input slot_three, input slot_four, input slot_five,
		output ready
	);
endinterface

// ===== rtl/hkrb_resolve.sv =====
module hkrb_resolve (
	input  logic [7:0]          key_code,
	input  logic                set,
	input  logic [7:0]          modifier,
	output hkrb_pkg::resolve_t  res
);
	import hkrb_pkg::*;

	logic [7:0] entry;
	logic [7:0] mod_bit;

	assign entry = CHAR_MAP[key_code[6:0]];
	assign mod_bit = 8'd1 << key_code[2:0];

	// raw usage, modifier bit, or ascii through the character map
	always_comb begin
		res.mapped = 1'b1;
		res.usage = 8'd0;
		res.modifier = modifier;
		if (key_code >= CODE_RAW_BASE) begin
			res.usage = key_code - CODE_RAW_BASE;
		end else if (key_code >= CODE_MODIFIER_BASE) begin
			res.modifier = set ? (modifier | mod_bit) : (modifier & ~mod_bit);
		end else if (entry == 8'd0) begin
			res.mapped = 1'b0;
		end else begin
			res.usage = entry & USAGE_MASK;
			if ((entry & SHIFT_FLAG) != 8'd0) begin
				res.modifier = set ? (modifier | LEFT_SHIFT_BIT)
					: (modifier & ~LEFT_SHIFT_BIT);
			end
		end
	end
endmodule

// ===== rtl/hid_keyboard_report_builder.sv =====
// channel      dir  payload                                       handshake
// event_ch     in   kind, key_code                                valid/ready
// report_ch    out  report_valid, status, last, modifier_bits,    valid/ready
//                   slot_zero .. slot_five
//
// press, release and release-all transactions each give one result; a type transaction
// gives two, as the held input register issues press then release.
// results leave through a single output register; input register and state
// update together, so a new transaction is taken each cycle the output drains, but for the press half of a type.
// reset clears the report state (all slots empty, no modifiers) and both
// valid flags; a stalled output holds the input register and its transaction.
module hid_keyboard_report_builder #(
	parameter int SLOT_COUNT = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hkrb_event_if.sink           event_ch,
	hkrb_report_if.source        report_ch
);
	import hkrb_pkg::*;

	localparam int SHOW = (SLOT_COUNT < SHOWN_SLOTS) ? SLOT_COUNT : SHOWN_SLOTS;

	// input register
	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] code_s1;
	logic       phase_s1;

	// result register
	logic       valid_s2;
	logic       report_valid_s2;
	logic [1:0] status_s2;
	logic       last_s2;
	logic [7:0] modifier_s2;
	logic [7:0] shown_s2 [SHOWN_SLOTS];

	// report state
	logic [7:0] modifier_q;
	logic [7:0] slots_q [SLOT_COUNT];

	logic       step;
	logic       is_release;
	logic       done_s1;
	resolve_t   res;
	logic       present;
	logic       has_free;
	logic [SLOT_COUNT-1:0] first_free;
	logic [7:0] modifier_next;
	logic [7:0] slots_next [SLOT_COUNT];
	logic       report_ok;
	logic [1:0] status_next;
	logic [7:0] shown_next [SHOWN_SLOTS];

	assign step = valid_s1 && (!valid_s2 || report_ch.ready);
	assign is_release = (kind_s1 == KIND_RELEASE) || ((kind_s1 == KIND_TYPE) && phase_s1);
	assign done_s1 = step && !((kind_s1 == KIND_TYPE) && !phase_s1);
	assign event_ch.ready = !valid_s1 || done_s1;

	hkrb_resolve u_resolve (
		.key_code (code_s1),
		.set      (!is_release),
		.modifier (modifier_q),
		.res      (res)
	);

	// slot search: presence and first empty slot
	always_comb begin
		logic found;
		present = 1'b0;
		found = 1'b0;
		first_free = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (slots_q[i] == res.usage) present = 1'b1;
			if (!found && slots_q[i] == 8'd0) begin
				first_free[i] = 1'b1;
				found = 1'b1;
			end
		end
		has_free = found;
	end

	// next report state and result status
	always_comb begin
		modifier_next = modifier_q;
		for (int i = 0; i < SLOT_COUNT; i++) slots_next[i] = slots_q[i];
		report_ok = 1'b1;
		status_next = STATUS_OK;
		if (kind_s1 == KIND_RELEASE_ALL) begin
			modifier_next = 8'd0;
			for (int i = 0; i < SLOT_COUNT; i++) slots_next[i] = 8'd0;
		end else if (!res.mapped) begin
			report_ok = 1'b0;
			status_next = STATUS_UNMAPPED;
		end else if (is_release) begin
			modifier_next = res.modifier;
			if (res.usage != 8'd0) begin
				for (int i = 0; i < SLOT_COUNT; i++)
					if (slots_q[i] == res.usage) slots_next[i] = 8'd0;
			end
		end else begin
			modifier_next = res.modifier;
			if (!present) begin
				if (has_free) begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (first_free[i]) slots_next[i] = res.usage;
				end else begin
					report_ok = 1'b0;
					status_next = STATUS_FULL;
				end
			end
		end
	end

	// shown slots, those past the slot count read zero
	always_comb begin
		for (int i = 0; i < SHOWN_SLOTS; i++) shown_next[i] = 8'd0;
		for (int i = 0; i < SHOW; i++) shown_next[i] = report_ok ? slots_next[i] : 8'd0;
	end

	// input register and type phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (event_ch.valid && event_ch.ready) begin
			valid_s1 <= 1'b1;
			phase_s1 <= 1'b0;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end else if (step) begin
			phase_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (event_ch.valid && event_ch.ready) begin
			kind_s1 <= event_ch.kind;
			code_s1 <= event_ch.key_code;
		end
	end

	// report state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modifier_q <= 8'd0;
			for (int i = 0; i < SLOT_COUNT; i++) slots_q[i] <= 8'd0;
		end else if (step) begin
			modifier_q <= modifier_next;
			for (int i = 0; i < SLOT_COUNT; i++) slots_q[i] <= slots_next[i];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (report_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			report_valid_s2 <= report_ok;
			status_s2 <= status_next;
			last_s2 <= !((kind_s1 == KIND_TYPE) && !phase_s1);
			modifier_s2 <= report_ok ? modifier_next : 8'd0;
			for (int i = 0; i < SHOWN_SLOTS; i++) shown_s2[i] <= shown_next[i];
		end
	end

	assign report_ch.valid = valid_s2;
	assign report_ch.report_valid = report_valid_s2;
	assign report_ch.status = status_s2;
	assign report_ch.last = last_s2;
	assign report_ch.modifier_bits = modifier_s2;
	assign report_ch.slot_zero = shown_s2[0];
	assign report_ch.slot_one = shown_s2[1];
	assign report_ch.slot_two = shown_s2[2];
	assign report_ch.slot_three = shown_s2[3];
	assign report_ch.slot_four = shown_s2[4];
	assign report_ch.slot_five = shown_s2[5];
endmodule

// ===== sim/tb_hid_keyboard_report_builder.sv =====
`timescale 1ns / 1ps

module tb_hid_keyboard_report_builder;
	import hkrb_pkg::*;

	localparam int NUM_SLOTS = 6;
	localparam int RANDOM_ITEMS = 1250;
	localparam int DIR_N = 26;
	localparam int POOL_N = 13;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;

	// one report transaction as seen on the output channel
	typedef struct packed {
		logic            report_valid;
		logic [1:0]      status;
		logic            last;
		logic [7:0]      modifier_bits;
		logic [5:0][7:0] slots;
	} report_t;

	// directed row: expectation given only where it is obvious
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] code;
		logic       typed;
		logic       rv;
		logic [1:0] st;
		logic [7:0] mods;
		logic [7:0] s0;
	} dir_row_t;

	logic clk;
	logic arst_n;

	hkrb_event_if  ev_if ();
	hkrb_report_if rpt_if ();

	hid_keyboard_report_builder #(
		.SLOT_COUNT(NUM_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.event_ch(ev_if),
		.report_ch(rpt_if)
	);

	// ascii to usage code, top bit adds left shift, zero means unmapped
	logic [7:0] ascii_usage [128] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
		8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
		8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
		8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
		8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
		8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
		8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
		8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
		8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
		8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
		8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
		8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
	};

	// directed sequence, starting from the reset state
	dir_row_t dir_rows [DIR_N] = '{
		'{KIND_PRESS,       8'h61, 1'b1, 1'b1, STATUS_OK,       8'h00, 8'h04},
		'{KIND_PRESS,       8'h00, 1'b1, 1'b0, STATUS_UNMAPPED, 8'h00, 8'h00},
		'{KIND_RELEASE,     8'h7f, 1'b1, 1'b0, STATUS_UNMAPPED, 8'h00, 8'h00},
		'{KIND_PRESS,       8'h41, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_PRESS,       8'hff, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_PRESS,       8'h88, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_PRESS,       8'h80, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_PRESS,       8'h87, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_PRESS,       8'h20, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_PRESS,       8'h0a, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_PRESS,       8'h31, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_PRESS,       8'h09, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_PRESS,       8'h62, 1'b1, 1'b0, STATUS_FULL,     8'h00, 8'h00},
		'{KIND_PRESS,       8'h87, 1'b1, 1'b0, STATUS_FULL,     8'h00, 8'h00},
		'{KIND_PRESS,       8'h42, 1'b1, 1'b0, STATUS_FULL,     8'h00, 8'h00},
		'{KIND_PRESS,       8'h61, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_RELEASE,     8'h80, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_RELEASE,     8'h88, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_RELEASE,     8'hff, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_PRESS,       8'h78, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_TYPE,        8'h40, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_TYPE,        8'h00, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_TYPE,        8'h71, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_RELEASE_ALL, 8'hff, 1'b1, 1'b1, STATUS_OK,       8'h00, 8'h00},
		'{KIND_TYPE,        8'hff, 1'b0, 1'b0, STATUS_OK,       8'h00, 8'h00},
		'{KIND_RELEASE_ALL, 8'h00, 1'b1, 1'b1, STATUS_OK,       8'h00, 8'h00}
	};

	// codes that recur often so presses and releases hit the same keys
	logic [7:0] key_pool [POOL_N] = '{
		8'h61, 8'h41, 8'h62, 8'h20, 8'h31, 8'h21, 8'h80,
		8'h81, 8'h87, 8'h88, 8'h90, 8'hff, 8'h00
	};

	// predicted keyboard state
	logic [7:0] mod_state;
	logic [7:0] slot_state [NUM_SLOTS];

	report_t pending_reports [$];

	int  err_cnt;
	int  items_sent;
	int  reports_seen;
	int  full_seen;
	int  unmapped_seen;
	int  idle_cycles;
	bit  calm_phase;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// builds a result from the predicted state
	function automatic report_t build_report(input logic rv, input logic [1:0] st,
		input logic is_last);
		report_t r;
		r = '0;
		r.report_valid = rv;
		r.status = st;
		r.last = is_last;
		if (rv) begin
			r.modifier_bits = mod_state;
			for (int i = 0; i < 6; i++)
				if (i < NUM_SLOTS)
					r.slots[i] = slot_state[i];
		end
		return r;
	endfunction

	// maps a key code to a usage code and applies its modifier effect
	function automatic void resolve_code(input logic [7:0] code, input bit set,
		output bit mapped, output logic [7:0] usage);
		logic [7:0] bit_mask;
		logic [7:0] entry;
		mapped = 1'b1;
		usage = 8'h00;
		bit_mask = 8'h00;
		if (code >= CODE_RAW_BASE) begin
			usage = code - CODE_RAW_BASE;
		end else if (code >= CODE_MODIFIER_BASE) begin
			bit_mask = 8'h01 << code[2:0];
			mod_state = set ? (mod_state | bit_mask) : (mod_state & ~bit_mask);
		end else begin
			entry = ascii_usage[code[6:0]];
			if (entry == 8'h00) begin
				mapped = 1'b0;
			end else begin
				if ((entry & SHIFT_FLAG) != 8'h00)
					mod_state = set ? (mod_state | LEFT_SHIFT_BIT)
						: (mod_state & ~LEFT_SHIFT_BIT);
				usage = entry & USAGE_MASK;
			end
		end
	endfunction

	function automatic report_t press_key(input logic [7:0] code, input logic is_last);
		bit         mapped;
		bit         present;
		bit         placed;
		logic [7:0] usage;
		resolve_code(code, 1'b1, mapped, usage);
		if (!mapped)
			return build_report(1'b0, STATUS_UNMAPPED, is_last);
		present = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_state[i] == usage)
				present = 1'b1;
		if (!present) begin
			placed = 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (!placed && slot_state[i] == 8'h00) begin
					slot_state[i] = usage;
					placed = 1'b1;
				end
			end
			if (!placed)
				return build_report(1'b0, STATUS_FULL, is_last);
		end
		return build_report(1'b1, STATUS_OK, is_last);
	endfunction

	function automatic report_t release_key(input logic [7:0] code, input logic is_last);
		bit         mapped;
		logic [7:0] usage;
		resolve_code(code, 1'b0, mapped, usage);
		if (!mapped)
			return build_report(1'b0, STATUS_UNMAPPED, is_last);
		if (usage != 8'h00)
			for (int i = 0; i < NUM_SLOTS; i++)
				if (slot_state[i] == usage)
					slot_state[i] = 8'h00;
		return build_report(1'b1, STATUS_OK, is_last);
	endfunction

	// advances the predicted state by one event and queues its reports
	function automatic void predict_event(input logic [1:0] kind, input logic [7:0] code);
		case (kind)
			KIND_PRESS: begin
				pending_reports.push_back(press_key(code, 1'b1));
			end
			KIND_RELEASE: begin
				pending_reports.push_back(release_key(code, 1'b1));
			end
			KIND_RELEASE_ALL: begin
				mod_state = 8'h00;
				for (int i = 0; i < NUM_SLOTS; i++)
					slot_state[i] = 8'h00;
				pending_reports.push_back(build_report(1'b1, STATUS_OK, 1'b1));
			end
			default: begin
				pending_reports.push_back(press_key(code, 1'b0));
				pending_reports.push_back(release_key(code, 1'b1));
			end
		endcase
	endfunction

	function automatic string report_str(input report_t r);
		return $sformatf("rv=%0d st=%0d last=%0d mod=%02h slots=%02h %02h %02h %02h %02h %02h",
			r.report_valid, r.status, r.last, r.modifier_bits, r.slots[0], r.slots[1],
			r.slots[2], r.slots[3], r.slots[4], r.slots[5]);
	endfunction

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_phase || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// drives one event transaction and waits until it is taken
	task automatic send_event(input logic [1:0] kind, input logic [7:0] code);
		int gap;
		ev_if.valid <= 1'b1;
		ev_if.kind <= kind;
		ev_if.key_code <= code;
		do @(posedge clk); while (ev_if.ready !== 1'b1);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			ev_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stimulus and end of run
	initial begin
		int         r;
		logic [1:0] kind;
		logic [7:0] code;
		err_cnt = 0;
		items_sent = 0;
		reports_seen = 0;
		full_seen = 0;
		unmapped_seen = 0;
		calm_phase = 1'b0;
		mod_state = 8'h00;
		for (int i = 0; i < NUM_SLOTS; i++)
			slot_state[i] = 8'h00;
		arst_n = 1'b0;
		ev_if.valid <= 1'b0;
		ev_if.kind <= KIND_PRESS;
		ev_if.key_code <= 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (int n = 0; n < DIR_N; n++) begin
			predict_event(dir_rows[n].kind, dir_rows[n].code);
			if (dir_rows[n].typed) begin
				void'(pending_reports.pop_back());
				pending_reports.push_back(report_t'{dir_rows[n].rv, dir_rows[n].st, 1'b1,
					dir_rows[n].mods, {40'h0, dir_rows[n].s0}});
			end
			send_event(dir_rows[n].kind, dir_rows[n].code);
		end

		// random part
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm_phase = (n >= 600 && n < 750);
			r = $urandom_range(0, 99);
			if (r < 40)
				kind = KIND_PRESS;
			else if (r < 66)
				kind = KIND_RELEASE;
			else if (r < 94)
				kind = KIND_TYPE;
			else
				kind = KIND_RELEASE_ALL;
			r = $urandom_range(0, 99);
			if (r < 35)
				code = key_pool[4'($urandom_range(0, POOL_N - 1))];
			else if (r < 60)
				code = 8'($urandom_range(32, 126));
			else if (r < 70)
				code = 8'($urandom_range(128, 135));
			else
				code = 8'($urandom_range(0, 255));
			predict_event(kind, code);
			send_event(kind, code);
		end
		calm_phase = 1'b0;
		ev_if.valid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d key events, checked %0d reports", items_sent, reports_seen);
		$display("  of which %0d full-report and %0d unmapped-character errors",
			full_seen, unmapped_seen);
		if (err_cnt == 0 && pending_reports.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// report sink with random back-pressure
	initial begin
		int gap;
		rpt_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			rpt_if.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rpt_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// compare each report transaction with the oldest prediction
	always @(posedge clk) begin
		report_t act;
		report_t exp_r;
		if (arst_n && rpt_if.valid === 1'b1 && rpt_if.ready === 1'b1) begin
			act.report_valid = rpt_if.report_valid;
			act.status = rpt_if.status;
			act.last = rpt_if.last;
			act.modifier_bits = rpt_if.modifier_bits;
			act.slots = {rpt_if.slot_five, rpt_if.slot_four, rpt_if.slot_three,
				rpt_if.slot_two, rpt_if.slot_one, rpt_if.slot_zero};
			reports_seen++;
			if (act.status == STATUS_FULL)
				full_seen++;
			if (act.status == STATUS_UNMAPPED)
				unmapped_seen++;
			if (pending_reports.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected report, expected none, actual %s", $time,
					report_str(act));
			end else begin
				exp_r = pending_reports.pop_front();
				if (act !== exp_r) begin
					err_cnt++;
					$display("%0t: report mismatch, expected %s, actual %s", $time,
						report_str(exp_r), report_str(act));
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (ev_if.valid === 1'b1 && ev_if.ready === 1'b1)
			|| (rpt_if.valid === 1'b1 && rpt_if.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
